[rtl/pfs_pkg.sv]
`default_nettype none
package pfs_pkg;
    localparam int ADDR_W = 32;
    localparam int CNT_W  = 32;

    localparam logic [1:0] KIND_FREE  = 2'd0;
    localparam logic [1:0] KIND_BAD   = 2'd1;
    localparam logic [1:0] KIND_ALLOC = 2'd2;

    localparam logic [1:0] STATUS_OK  = 2'd0;
    localparam logic [1:0] STATUS_OOM = 2'd1;
    localparam logic [1:0] STATUS_BAD = 2'd2;

    localparam logic [1:0] REG_LOWEST = 2'd0;
    localparam logic [1:0] REG_TOP    = 2'd1;

    localparam logic [ADDR_W-1:0] LOWEST_RESET = 32'h8000_0000;
    localparam logic [ADDR_W-1:0] TOP_RESET    = 32'h8800_0000;

    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
    } t_cmd_ctl;
endpackage
`default_nettype wire

[rtl/pfs_front.sv]
`default_nettype none
module pfs_front #(
    parameter int CPUS       = 8,
    parameter int PAGES      = 32768,
    parameter int PAGE_BYTES = 4096,
    localparam int CW = (CPUS > 1) ? $clog2(CPUS) : 1,
    localparam int IW = $clog2(PAGES),
    localparam int SH = $clog2(PAGE_BYTES)
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_valid,
    output logic                          o_stall,
    input  wire                           i_action,
    input  wire  [2:0]                    i_cpu,
    input  wire  [pfs_pkg::ADDR_W-1:0]    i_address,
    input  wire                           i_cfg_valid,
    input  wire  [1:0]                    i_cfg_index,
    input  wire  [pfs_pkg::ADDR_W-1:0]    i_cfg_data,
    output pfs_pkg::t_cmd_ctl             o_cmd,
    output logic [CW-1:0]                 o_cmd_cpu,
    output logic [IW-1:0]                 o_cmd_idx,
    input  wire                           i_cmd_pop,
    output logic [pfs_pkg::ADDR_W:0]      o_base
);
    logic [pfs_pkg::ADDR_W-1:0] r_lowest, r_top;
    logic [1:0]    r_q_kind [2];
    logic [CW-1:0] r_q_cpu  [2];
    logic [IW-1:0] r_q_idx  [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic [pfs_pkg::ADDR_W:0] w_sum, w_diff, w_pidx;
    logic [1:0]    w_kind;
    logic [CW-1:0] w_cpu;
    logic          w_push, w_pop;

    function automatic logic [CW-1:0] cpu_mod(input logic [2:0] c);
        logic [4:0] v;
        v = {2'b00, c};
        for (int k = 0; k < 4; k++) begin
            if (v >= 5'(CPUS)) v = v - 5'(CPUS);
        end
        return CW'(v);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lowest <= pfs_pkg::LOWEST_RESET;
            r_top    <= pfs_pkg::TOP_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == pfs_pkg::REG_LOWEST) r_lowest <= i_cfg_data;
            if (i_cfg_index == pfs_pkg::REG_TOP)    r_top    <= i_cfg_data;
        end
    end

    // base = lowest rounded up to a page, may reach 2^32
    assign w_sum  = {1'b0, r_lowest} + (pfs_pkg::ADDR_W+1)'(PAGE_BYTES - 1);
    assign o_base = {w_sum[pfs_pkg::ADDR_W:SH], {SH{1'b0}}};
    assign w_diff = {1'b0, i_address} - o_base;
    assign w_pidx = w_diff >> SH;
    assign w_cpu  = cpu_mod(i_cpu);

    always_comb begin
        if (i_action) begin
            w_kind = pfs_pkg::KIND_ALLOC;
        end else if (i_address[SH-1:0] != '0 || i_address < r_lowest ||
                     i_address >= r_top || {1'b0, i_address} < o_base ||
                     w_pidx >= (pfs_pkg::ADDR_W+1)'(PAGES)) begin
            w_kind = pfs_pkg::KIND_BAD;
        end else begin
            w_kind = pfs_pkg::KIND_FREE;
        end
    end

    assign o_stall = (r_cnt == 2'd2);
    assign w_push  = i_valid && !o_stall;
    assign w_pop   = i_cmd_pop && (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (w_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q_kind[r_wp] <= w_kind;
            r_q_cpu[r_wp]  <= w_cpu;
            r_q_idx[r_wp]  <= w_pidx[IW-1:0];
        end
    end

    assign o_cmd.valid = (r_cnt != 2'd0);
    assign o_cmd.kind  = r_q_kind[r_rp];
    assign o_cmd_cpu   = r_q_cpu[r_rp];
    assign o_cmd_idx   = r_q_idx[r_rp];
endmodule
`default_nettype wire

[rtl/pfs_back.sv]
`default_nettype none
module pfs_back #(
    parameter int CPUS       = 8,
    parameter int PAGES      = 32768,
    parameter int PAGE_BYTES = 4096,
    localparam int CW = (CPUS > 1) ? $clog2(CPUS) : 1,
    localparam int IW = $clog2(PAGES),
    localparam int SH = $clog2(PAGE_BYTES)
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  pfs_pkg::t_cmd_ctl             i_cmd,
    input  wire  [CW-1:0]                 i_cmd_cpu,
    input  wire  [IW-1:0]                 i_cmd_idx,
    output logic                          o_cmd_pop,
    input  wire  [pfs_pkg::ADDR_W:0]      i_base,
    output logic                          o_valid,
    input  wire                           i_stall,
    output logic [pfs_pkg::ADDR_W-1:0]    o_page_addr,
    output logic [1:0]                    o_status
);
    localparam int PW = IW + SH;
    localparam int SW = ((PW > pfs_pkg::ADDR_W + 1) ? PW : pfs_pkg::ADDR_W + 1) + 1;
    localparam int CN = pfs_pkg::CNT_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_POP  = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_SPOP = 3'd3;
    localparam logic [2:0] S_WALK = 3'd4;

    logic [IW-1:0] r_mem [PAGES];
    logic [IW-1:0] r_rdata;
    logic [IW-1:0] r_head [CPUS];
    logic [CN-1:0] r_cnt  [CPUS];
    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_cpu, r_d;
    logic [CW-1:0] r_i;
    logic [IW-1:0] r_page;
    logic [CN-1:0] r_rem;
    logic          r_ovalid;
    logic [pfs_pkg::ADDR_W-1:0] r_page_addr;
    logic [1:0]    r_status;

    logic          w_free;
    logic [CW-1:0] w_sel, w_dn;
    logic [IW-1:0] w_head, w_raddr;
    logic [CN-1:0] w_cnt, w_left, w_take;
    logic          w_we, w_out;
    logic [1:0]    w_ostat;
    logic [pfs_pkg::ADDR_W-1:0] w_page_addr;

    assign w_free = !r_ovalid || !i_stall;
    assign w_sel  = (r_state == S_IDLE) ? i_cmd_cpu : r_d;
    assign w_head = r_head[w_sel];
    assign w_cnt  = r_cnt[w_sel];
    assign w_dn   = (r_d == CW'(CPUS - 1)) ? '0 : r_d + 1'b1;
    assign w_left = w_cnt - 1'b1;
    assign w_take = (w_left >> 1) + 1'b1;
    assign w_page_addr = pfs_pkg::ADDR_W'(SW'(i_base) + (SW'(r_page) << SH));
    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd.valid && w_free;

    always_comb begin
        n_state = r_state;
        w_raddr = r_rdata;
        w_we    = 1'b0;
        w_out   = 1'b0;
        w_ostat = pfs_pkg::STATUS_OK;
        case (r_state)
            S_IDLE: begin
                w_raddr = w_head;
                if (o_cmd_pop) begin
                    case (i_cmd.kind)
                        pfs_pkg::KIND_FREE: begin
                            w_we  = 1'b1;
                            w_out = 1'b1;
                        end
                        pfs_pkg::KIND_ALLOC: begin
                            n_state = (w_cnt != '0) ? S_POP : S_SCAN;
                        end
                        default: begin
                            w_out   = 1'b1;
                            w_ostat = pfs_pkg::STATUS_BAD;
                        end
                    endcase
                end
            end
            S_POP: begin
                w_out   = 1'b1;
                n_state = S_IDLE;
            end
            S_SCAN: begin
                w_raddr = w_head;
                if (w_cnt != '0) begin
                    n_state = S_SPOP;
                end else if (r_i == CW'(CPUS - 1)) begin
                    w_out   = 1'b1;
                    w_ostat = pfs_pkg::STATUS_OOM;
                    n_state = S_IDLE;
                end
            end
            S_SPOP: begin
                w_out   = 1'b1;
                n_state = (w_left > 1) ? S_WALK : S_IDLE;
            end
            S_WALK: begin
                if (r_rem == CN'(1)) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[i_cmd_idx] <= (w_cnt != '0) ? w_head : '0;
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            for (int k = 0; k < CPUS; k++) r_cnt[k] <= '0;
        end else begin
            r_state <= n_state;
            if (w_out)        r_ovalid <= 1'b1;
            else if (!i_stall) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (o_cmd_pop && i_cmd.kind == pfs_pkg::KIND_FREE) begin
                        r_head[w_sel] <= i_cmd_idx;
                        if (w_cnt != '1) r_cnt[w_sel] <= w_cnt + 1'b1;
                    end
                end
                S_POP: begin
                    r_head[r_cpu] <= r_rdata;
                    r_cnt[r_cpu]  <= r_cnt[r_cpu] - 1'b1;
                end
                S_SPOP: begin
                    if (w_left > 1) begin
                        r_head[r_cpu] <= r_rdata;
                        r_cnt[r_cpu]  <= w_take;
                        r_cnt[r_d]    <= w_left - w_take;
                    end else begin
                        r_head[r_d] <= r_rdata;
                        r_cnt[r_d]  <= w_left;
                    end
                end
                S_WALK: begin
                    if (r_rem == CN'(1)) r_head[r_d] <= r_rdata;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_cpu  <= i_cmd_cpu;
                r_d    <= (i_cmd_cpu == CW'(CPUS - 1)) ? '0 : i_cmd_cpu + 1'b1;
                r_i    <= CW'(1);
                r_page <= w_head;
            end
            S_SCAN: begin
                r_page <= w_head;
                if (w_cnt == '0) begin
                    r_d <= w_dn;
                    r_i <= r_i + 1'b1;
                end
            end
            S_SPOP: r_rem <= w_take;
            S_WALK: r_rem <= r_rem - 1'b1;
            default: ;
        endcase
        if (w_out) begin
            r_status    <= w_ostat;
            r_page_addr <= (w_ostat == pfs_pkg::STATUS_OK &&
                            r_state != S_IDLE) ? w_page_addr : '0;
        end
    end

    assign o_valid     = r_ovalid;
    assign o_page_addr = r_page_addr;
    assign o_status    = r_status;
endmodule
`default_nettype wire

[rtl/per_cpu_page_free_stacks_steal_top.sv]
// Per-CPU page allocator with stealing. A free is done in the back end's
// idle state; an own-list alloc adds a pop state for one link-store read.
// An alloc that steals scans the other CPUs in turn, pops the victim list
// and, when more than one entry remains on it, walks it; the walk reads
// one link a cycle from the next-link memory, and the result word leaves
// before the walk ends. An alloc that finds every list empty gets OOM.
// A two-word command queue lets the front accept while the back works.
// Frees are checked against lowest_addr/top_addr, alignment and PAGES.
`default_nettype none
module per_cpu_page_free_stacks_steal_top #(
    parameter int CPUS       = 8,
    parameter int PAGES      = 32768,
    parameter int PAGE_BYTES = 4096
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_stall,
    input  wire                          i_action,
    input  wire  [2:0]                   i_cpu,
    input  wire  [pfs_pkg::ADDR_W-1:0]   i_address,
    output logic                         o_valid,
    input  wire                          i_stall,
    output logic [pfs_pkg::ADDR_W-1:0]   o_page_addr,
    output logic [1:0]                   o_status,
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire  [1:0]                   i_cfg_index,
    input  wire  [pfs_pkg::ADDR_W-1:0]   i_cfg_data
);
    localparam int CW = (CPUS > 1) ? $clog2(CPUS) : 1;
    localparam int IW = $clog2(PAGES);

    pfs_pkg::t_cmd_ctl        w_cmd;
    logic [CW-1:0]            w_cmd_cpu;
    logic [IW-1:0]            w_cmd_idx;
    logic                     w_cmd_pop;
    logic [pfs_pkg::ADDR_W:0] w_base;

    assign o_cfg_ready = 1'b1;

    pfs_front #(.CPUS(CPUS), .PAGES(PAGES), .PAGE_BYTES(PAGE_BYTES)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_action, .i_cpu, .i_address,
        .i_cfg_valid, .i_cfg_index, .i_cfg_data,
        .o_cmd(w_cmd), .o_cmd_cpu(w_cmd_cpu), .o_cmd_idx(w_cmd_idx),
        .i_cmd_pop(w_cmd_pop), .o_base(w_base)
    );

    pfs_back #(.CPUS(CPUS), .PAGES(PAGES), .PAGE_BYTES(PAGE_BYTES)) u_back (
        .i_clk, .i_rst_n,
        .i_cmd(w_cmd), .i_cmd_cpu(w_cmd_cpu), .i_cmd_idx(w_cmd_idx),
        .o_cmd_pop(w_cmd_pop), .i_base(w_base),
        .o_valid, .i_stall, .o_page_addr, .o_status
    );
endmodule
`default_nettype wire

[tb/sv/per_cpu_page_free_stacks_steal_top_tb.sv]
`timescale 1ns / 1ps
module per_cpu_page_free_stacks_steal_top_tb;

    localparam int CPUS       = 8;
    localparam int PAGES      = 32768;
    localparam int PAGE_BYTES = 4096;
    localparam logic ACT_FREE  = 1'b0;
    localparam logic ACT_ALLOC = 1'b1;
    localparam int PHASE_ITEMS = 225;
    localparam int STALL_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic        action;
        logic [2:0]  cpu;
        logic [31:0] address;
    } t_req;

    typedef struct {
        logic [31:0] page_addr;
        logic [1:0]  status;
    } t_rsp;

    typedef struct {
        t_req req;
        logic known;
        t_rsp rsp;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_action;
    logic [2:0]  i_cpu;
    logic [31:0] i_address;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_page_addr;
    logic [1:0]  o_status;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    per_cpu_page_free_stacks_steal_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_action(i_action), .i_cpu(i_cpu), .i_address(i_address),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_page_addr(o_page_addr), .o_status(o_status),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b1; #2;
        i_clk = 1'b0; #2;
    end

    // allocator shadow state
    logic [31:0] lowest_q;
    logic [31:0] top_q;
    logic [14:0] link_mem [PAGES];
    logic [14:0] head_q [CPUS];
    logic [31:0] count_q [CPUS];

    t_rsp expected_words[$];
    int   errors;
    int   send_idle_pct;
    int   recv_stall_pct;
    logic hold_req;
    logic hold_done;
    int   hold_cnt;
    int   quiet_cycles;

    function automatic logic [63:0] page_base();
        return ((64'(lowest_q) + PAGE_BYTES - 1) / PAGE_BYTES) * PAGE_BYTES;
    endfunction

    function automatic logic [14:0] pop_page(int c);
        logic [14:0] r;
        r = head_q[c];
        head_q[c] = link_mem[r];
        count_q[c] = count_q[c] - 1;
        return r;
    endfunction

    function automatic t_rsp allocate_or_free(t_req q);
        t_rsp        o;
        logic [63:0] base;
        logic [63:0] idx;
        logic [14:0] r;
        logic [14:0] tail;
        logic [31:0] left;
        logic [31:0] take;
        int          c;
        int          d;
        logic        found;
        base = page_base();
        c = q.cpu % CPUS;
        o.page_addr = '0;
        o.status = pfs_pkg::STATUS_OK;
        found = 1'b0;
        r = '0;
        if (q.action == ACT_FREE) begin
            if (q.address[11:0] != 0 || q.address < lowest_q || q.address >= top_q ||
                64'(q.address) < base) begin
                o.status = pfs_pkg::STATUS_BAD;
                return o;
            end
            idx = (64'(q.address) - base) / PAGE_BYTES;
            if (idx >= PAGES) begin
                o.status = pfs_pkg::STATUS_BAD;
                return o;
            end
            link_mem[idx[14:0]] = (count_q[c] != 0) ? head_q[c] : '0;
            head_q[c] = idx[14:0];
            if (count_q[c] != 32'hFFFF_FFFF) count_q[c] = count_q[c] + 1;
            return o;
        end
        if (count_q[c] != 0) begin
            r = pop_page(c);
            found = 1'b1;
        end else begin
            for (int i = 1; i < CPUS && !found; i++) begin
                d = (c + i) % CPUS;
                if (count_q[d] != 0) begin
                    r = pop_page(d);
                    found = 1'b1;
                    left = count_q[d];
                    if (left > 1) begin
                        // move half plus one of the victim list, order kept
                        take = left / 2 + 1;
                        tail = head_q[d];
                        head_q[c] = tail;
                        for (int k = 1; k < take; k++) tail = link_mem[tail];
                        head_q[d] = link_mem[tail];
                        count_q[d] = left - take;
                        count_q[c] = take;
                    end
                end
            end
        end
        if (found) o.page_addr = 32'(base + 64'(r) * PAGE_BYTES);
        else o.status = pfs_pkg::STATUS_OOM;
        return o;
    endfunction

    function automatic t_req random_request();
        t_req        q;
        logic [63:0] base;
        logic [63:0] npg;
        int          sel;
        logic [63:0] idx;
        base = page_base();
        npg = (64'(top_q) > base) ? (64'(top_q) - base + PAGE_BYTES - 1) / PAGE_BYTES : 0;
        if (npg > PAGES) npg = PAGES;
        sel = $urandom_range(99);
        q.cpu = 3'($urandom_range(7));
        q.address = $urandom;
        q.action = ACT_ALLOC;
        if (sel < 50 && npg != 0) begin
            q.action = ACT_FREE;
            if ($urandom_range(9) < 7) q.cpu = 3'($urandom_range(3));
            idx = ($urandom_range(9) == 0) ? $urandom_range(32'(npg - 1))
                                            : $urandom_range(32'(npg < 64 ? npg - 1 : 63));
            q.address = 32'(base + idx * PAGE_BYTES);
        end else if (sel >= 88 || sel < 50) begin
            q.action = ACT_FREE;
            case ($urandom_range(3))
                0: q.address = $urandom;
                1: q.address = 32'(base + 64'($urandom_range(63)) * PAGE_BYTES
                                   + $urandom_range(1, PAGE_BYTES - 1));
                2: q.address = 32'(base + 64'(PAGES + $urandom_range(3)) * PAGE_BYTES);
                default: q.address = {top_q[31:12], 12'h000};
            endcase
        end
        return q;
    endfunction

    task automatic send_word(t_req q, logic known, t_rsp want);
        t_rsp got;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            i_action <= 1'($urandom);
            i_address <= $urandom;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_action <= q.action;
        i_cpu <= q.cpu;
        i_address <= q.address;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        got = allocate_or_free(q);
        expected_words.push_back(known ? want : got);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] index, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (index == pfs_pkg::REG_LOWEST) lowest_q = data;
        else if (index == pfs_pkg::REG_TOP) top_q = data;
    endtask

    // receiver: check each word, then pick the stall for the next cycle
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word page_addr=%h status=%0d",
                             $realtime, o_page_addr, o_status);
                    errors++;
                end else begin
                    t_rsp e;
                    e = expected_words.pop_front();
                    if (o_page_addr !== e.page_addr) begin
                        $display("%0t: page_addr expected %h actual %h",
                                 $realtime, e.page_addr, o_page_addr);
                        errors++;
                    end
                    if (o_status !== e.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $realtime, e.status, o_status);
                        errors++;
                    end
                end
            end
            if (hold_req && !hold_done) begin
                i_stall <= 1'b1;
                hold_cnt <= hold_cnt + 1;
                if (hold_cnt == HOLD_CYCLES) hold_done <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    t_dir_row dir_rows[$];

    function automatic t_dir_row row(logic act, int c, logic [31:0] a, logic known = 1'b0,
                                     logic [31:0] pa = '0,
                                     logic [1:0] st = pfs_pkg::STATUS_OK);
        t_dir_row r;
        r.req.action = act;
        r.req.cpu = 3'(c);
        r.req.address = a;
        r.known = known;
        r.rsp.page_addr = pa;
        r.rsp.status = st;
        return r;
    endfunction

    initial begin
        errors = 0;
        quiet_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 1'b0;
        hold_done = 1'b0;
        hold_cnt = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_action = ACT_FREE;
        i_cpu = '0;
        i_address = '0;
        i_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = pfs_pkg::REG_LOWEST;
        i_cfg_data = '0;
        lowest_q = pfs_pkg::LOWEST_RESET;
        top_q = pfs_pkg::TOP_RESET;
        for (int c = 0; c < CPUS; c++) begin
            head_q[c] = '0;
            count_q[c] = '0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        dir_rows.push_back(row(ACT_ALLOC, 0, 32'h0, 1'b1, 32'h0, pfs_pkg::STATUS_OOM));
        dir_rows.push_back(row(ACT_FREE, 1, 32'h8000_0800, 1'b1, 32'h0, pfs_pkg::STATUS_BAD));
        dir_rows.push_back(row(ACT_FREE, 1, 32'h7FFF_F000, 1'b1, 32'h0, pfs_pkg::STATUS_BAD));
        dir_rows.push_back(row(ACT_FREE, 1, 32'h8800_0000, 1'b1, 32'h0, pfs_pkg::STATUS_BAD));
        dir_rows.push_back(row(ACT_FREE, 1, 32'hFFFF_FFFF, 1'b1, 32'h0, pfs_pkg::STATUS_BAD));
        dir_rows.push_back(row(ACT_FREE, 1, 32'h0000_0000, 1'b1, 32'h0, pfs_pkg::STATUS_BAD));
        dir_rows.push_back(row(ACT_FREE, 7, 32'h8000_0000, 1'b1, 32'h0, pfs_pkg::STATUS_OK));
        dir_rows.push_back(row(ACT_ALLOC, 7, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000,
                               pfs_pkg::STATUS_OK));
        dir_rows.push_back(row(ACT_FREE, 3, 32'h87FF_F000, 1'b1, 32'h0, pfs_pkg::STATUS_OK));
        dir_rows.push_back(row(ACT_ALLOC, 1, 32'h0, 1'b1, 32'h87FF_F000, pfs_pkg::STATUS_OK));
        for (int k = 0; k < 6; k++) dir_rows.push_back(row(ACT_FREE, 2, 32'h8000_0000 + k * 4096));
        dir_rows.push_back(row(ACT_ALLOC, 1, 32'h0));   // steal from cpu 2
        dir_rows.push_back(row(ACT_ALLOC, 1, 32'h0));
        dir_rows.push_back(row(ACT_FREE, 7, 32'h8000_0000));
        dir_rows.push_back(row(ACT_ALLOC, 6, 32'h0));   // steal from cpu 7, the top cpu
        dir_rows.push_back(row(ACT_FREE, 0, 32'h8000_0000));  // double free pushes again
        dir_rows.push_back(row(ACT_FREE, 0, 32'h8000_0000));
        dir_rows.push_back(row(ACT_ALLOC, 5, 32'h0));
        dir_rows.push_back(row(ACT_ALLOC, 5, 32'h0));
        dir_rows.push_back(row(ACT_ALLOC, 4, 32'h0));
        foreach (dir_rows[n]) send_word(dir_rows[n].req, dir_rows[n].known, dir_rows[n].rsp);

        for (int ph = 0; ph < 6; ph++) begin
            drain();
            case (ph)
                1: begin
                    write_reg(pfs_pkg::REG_LOWEST, 32'h8000_0800);
                    write_reg(pfs_pkg::REG_TOP, 32'h8004_0000);
                    send_idle_pct = 74; recv_stall_pct = 0;
                end
                2: begin
                    write_reg(pfs_pkg::REG_LOWEST, 32'h0000_0000);
                    write_reg(pfs_pkg::REG_TOP, 32'hFFFF_FFFF);
                    send_idle_pct = 0; recv_stall_pct = 74;
                end
                3: begin
                    write_reg(pfs_pkg::REG_LOWEST, 32'hFFFF_F000);
                    send_idle_pct = 28; recv_stall_pct = 28;
                end
                4: begin
                    write_reg(pfs_pkg::REG_LOWEST, 32'hFFFF_FFFF);
                    write_reg(pfs_pkg::REG_TOP, 32'h0000_0000);
                    send_idle_pct = 0; recv_stall_pct = 74;
                end
                5: begin
                    write_reg(pfs_pkg::REG_LOWEST, pfs_pkg::LOWEST_RESET);
                    write_reg(pfs_pkg::REG_TOP, pfs_pkg::TOP_RESET);
                    send_idle_pct = 0; recv_stall_pct = 0;
                    hold_req = 1'b1;   // long receiver hold-off, sender keeps offering
                end
                default: ;
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) send_word(random_request(), 1'b0, '{default: '0});
        end
        i_valid <= 1'b0;
        recv_stall_pct = 0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end
endmodule
